@@ src/edfs_pkg.sv @@
`default_nettype none
package edfs_pkg;

  localparam int MAX_TASKS = 16;
  localparam int MAX_SLOTS = 256;

  localparam int IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int TOTAL_W = $clog2(MAX_TASKS + 1);
  localparam int SLOT_W  = $clog2(MAX_SLOTS);
  localparam int FIELD_W = 8;
  localparam int CMP_W   = (SLOT_W > FIELD_W) ? SLOT_W : FIELD_W;

  localparam int CMD_W      = 2;
  localparam int KIND_W     = 2;
  localparam int TASK_W     = 4;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(MAX_SLOTS - 1);
  localparam logic [TOTAL_W-1:0] TOTAL_FULL = TOTAL_W'(MAX_TASKS);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_IDLE     = 2'd0,
    KIND_SERVED   = 2'd1,
    KIND_RESERVED = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [FIELD_W-1:0] slots_needed;
    logic [FIELD_W-1:0] deadline_slot;
    logic [FIELD_W-1:0] release_slot;
  } task_t;

  typedef struct packed {
    logic               active;
    logic               reserved;
    logic               found;
    logic [FIELD_W-1:0] best;
    logic [IDX_W-1:0]   pick;
    logic [1:0]         undone;
    logic               pick_fin;
  } token_t;

endpackage
`default_nettype wire

@@ src/edfs_cell.sv @@
`default_nettype none
module edfs_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [edfs_pkg::IDX_W-1:0]     cell_idx,
  input  logic                           occ,
  input  logic [edfs_pkg::SLOT_W-1:0]    slot,
  input  logic                           load_en,
  input  logic [edfs_pkg::IDX_W-1:0]     load_idx,
  input  edfs_pkg::task_t                load_task,
  input  logic                           serve_en,
  input  logic [edfs_pkg::IDX_W-1:0]     serve_idx,
  input  edfs_pkg::token_t               tok_in,
  output edfs_pkg::token_t               tok_out
);

  logic [edfs_pkg::FIELD_W-1:0] rel_r;
  logic [edfs_pkg::FIELD_W-1:0] ddl_r;
  logic [edfs_pkg::FIELD_W-1:0] need_r;
  logic [edfs_pkg::FIELD_W-1:0] srv_r;
  edfs_pkg::token_t             tok_r;
  edfs_pkg::token_t             tok_nxt;

  logic [edfs_pkg::CMP_W-1:0] slot_c;
  logic [edfs_pkg::CMP_W-1:0] rel_c;
  logic [edfs_pkg::CMP_W-1:0] ddl_c;
  logic                       hit;
  logic                       undone;
  logic                       cand;
  logic                       take;

  assign slot_c = edfs_pkg::CMP_W'(slot);
  assign rel_c  = edfs_pkg::CMP_W'(rel_r);
  assign ddl_c  = edfs_pkg::CMP_W'(ddl_r);

  assign hit    = occ && (ddl_c == slot_c);
  assign undone = occ && (srv_r < need_r);
  assign cand   = undone && (rel_c <= slot_c) && (ddl_c > slot_c);
  assign take   = cand && (!tok_in.found || (ddl_r < tok_in.best));

  always_comb begin
    tok_nxt = tok_in;
    tok_nxt.reserved = tok_in.reserved | hit;
    if (take) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.best     = ddl_r;
      tok_nxt.pick     = cell_idx;
      tok_nxt.pick_fin = (({1'b0, srv_r} + 9'd1) == {1'b0, need_r});
    end
    if (undone && (tok_in.undone != 2'd2)) begin
      tok_nxt.undone = tok_in.undone + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && (load_idx == cell_idx)) begin
      rel_r  <= load_task.release_slot;
      ddl_r  <= load_task.deadline_slot;
      need_r <= load_task.slots_needed;
      srv_r  <= '0;
    end else if (serve_en && (serve_idx == cell_idx)) begin
      srv_r <= srv_r + 8'd1;
    end
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

@@ src/edf_slot_scheduler.sv @@
`default_nettype none
// Channel | Direction | tdata (lowest bit up)                         | tuser
// in_     | input     | release_slot, deadline_slot, slots_needed     | command
// out_    | output    | slot_number, task_served, all_complete        | slot_kind
//
// On an advance beat a decision token walks the row of task cells one cell per cycle,
// then the result is registered and the chosen task is charged one slot unless the
// slot is reserved.
// Reset is synchronous and active low; it empties the table and rewinds the slot.
// A stalled result holds the block until out_tready takes it.
module edf_slot_scheduler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [edfs_pkg::IN_DATA_W-1:0]     in_tdata,   // release_slot, deadline_slot, slots_needed
  input  logic [edfs_pkg::CMD_W-1:0]         in_tuser,   // command
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [edfs_pkg::OUT_DATA_W-1:0]    out_tdata,  // slot_number, task_served, all_complete
  output logic [edfs_pkg::KIND_W-1:0]        out_tuser   // slot_kind
);

  edfs_pkg::state_t                 state_r;
  edfs_pkg::state_t                 state_nxt;
  logic [edfs_pkg::SLOT_W-1:0]      slot_r;
  logic [edfs_pkg::SLOT_W-1:0]      slot_nxt;
  logic [edfs_pkg::TOTAL_W-1:0]     total_r;
  edfs_pkg::token_t                 fin_r;
  logic                             out_valid_r;
  logic [edfs_pkg::FIELD_W-1:0]     out_slot_r;
  logic [edfs_pkg::TASK_W-1:0]      out_task_r;
  logic                             out_all_r;
  edfs_pkg::kind_t                  out_kind_r;

  logic              in_acc;
  logic              clear;
  logic              start;
  logic              load_en;
  logic              fin_cap;
  logic              emit;
  logic              serve_en;
  edfs_pkg::task_t   load_task;
  edfs_pkg::token_t  tok [edfs_pkg::MAX_TASKS+1];
  logic [edfs_pkg::MAX_TASKS-1:0] occ;

  assign in_tready = (state_r == edfs_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign clear     = in_acc && (in_tuser == edfs_pkg::CMD_CLEAR);
  assign load_task = edfs_pkg::task_t'(in_tdata);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      edfs_pkg::ST_IDLE: begin
        if (in_acc && (in_tuser == edfs_pkg::CMD_STEP)) state_nxt = edfs_pkg::ST_SCAN;
      end
      edfs_pkg::ST_SCAN: begin
        if (tok[edfs_pkg::MAX_TASKS].active) state_nxt = edfs_pkg::ST_FIN;
      end
      edfs_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) state_nxt = edfs_pkg::ST_IDLE;
      end
      default: state_nxt = edfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    start    = 1'b0;
    load_en  = 1'b0;
    fin_cap  = 1'b0;
    emit     = 1'b0;
    unique case (state_r)
      edfs_pkg::ST_IDLE: begin
        start   = in_acc && (in_tuser == edfs_pkg::CMD_STEP);
        load_en = in_acc && (in_tuser == edfs_pkg::CMD_LOAD) &&
                  (total_r < edfs_pkg::TOTAL_FULL);
      end
      edfs_pkg::ST_SCAN: begin
        fin_cap = tok[edfs_pkg::MAX_TASKS].active;
      end
      edfs_pkg::ST_FIN: begin
        emit = !out_valid_r || out_tready;
      end
      default: begin
        start = 1'b0;
      end
    endcase
  end

  always_comb begin
    slot_nxt = slot_r;
    if (clear) begin
      slot_nxt = '0;
    end else if (start && (slot_r != edfs_pkg::SLOT_LAST)) begin
      slot_nxt = slot_r + 1'b1;
    end
  end

  assign serve_en = emit && fin_r.found && !fin_r.reserved;

  always_comb begin
    tok[0]        = '0;
    tok[0].active = start;
  end

  for (genvar i = 0; i < edfs_pkg::MAX_TASKS; i++) begin : g_cell
    assign occ[i] = (edfs_pkg::TOTAL_W'(i) < total_r);
    edfs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (edfs_pkg::IDX_W'(i)),
      .occ       (occ[i]),
      .slot      (slot_nxt),
      .load_en   (load_en),
      .load_idx  (total_r[edfs_pkg::IDX_W-1:0]),
      .load_task (load_task),
      .serve_en  (serve_en),
      .serve_idx (fin_r.pick),
      .tok_in    (tok[i]),
      .tok_out   (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= edfs_pkg::ST_IDLE;
      slot_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      if (clear) begin
        total_r <= '0;
      end else if (load_en) begin
        total_r <= total_r + 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_cap) fin_r <= tok[edfs_pkg::MAX_TASKS];
    if (emit) begin
      out_slot_r <= edfs_pkg::FIELD_W'(slot_r);
      if (fin_r.reserved) begin
        out_kind_r <= edfs_pkg::KIND_RESERVED;
        out_task_r <= '0;
      end else if (fin_r.found) begin
        out_kind_r <= edfs_pkg::KIND_SERVED;
        out_task_r <= edfs_pkg::TASK_W'(fin_r.pick);
      end else begin
        out_kind_r <= edfs_pkg::KIND_IDLE;
        out_task_r <= '0;
      end
      out_all_r <= (fin_r.undone == 2'd0) ||
                   (serve_en && (fin_r.undone == 2'd1) && fin_r.pick_fin);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_all_r, out_task_r, out_slot_r};
  assign out_tuser  = out_kind_r;

endmodule
`default_nettype wire
